// ===== hw/rtl/ucbc_pkg.sv =====
// Shared types and constants of the usage-count block cache.
package ucbc_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int DATA_BITS   = 64;
    localparam int ID_W        = 64;
    localparam int USE_W       = 7;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int STAT_W      = 32;

    typedef enum logic [1:0] {
        KIND_STORE    = 2'd0,
        KIND_RETRIEVE = 2'd1,
        KIND_DROP     = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_AGE,
        ST_MINSCAN,
        ST_SHIFT,
        ST_APPEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [USE_W-1:0]     usage;
        logic [DATA_BITS-1:0] data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                 found;
        logic [DATA_BITS-1:0] read_data;
        logic [STAT_W-1:0]    hit_count;
        logic [STAT_W-1:0]    miss_count;
    } result_t;

endpackage

// ===== hw/rtl/ucbc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ucbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ucbc_engine.sv =====
// Sequencer that searches, ages, evicts and compacts the entry memory.
module ucbc_engine
    import ucbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [USE_W-1:0] max_blocks,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_kind,
    input  logic [ID_W-1:0]  in_id,
    input  logic [DATA_BITS-1:0] in_data,
    output mem_req_t         mem_req,
    input  entry_t           mem_rdata,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 pv_reg, pv_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [USE_W-1:0]     bestu_reg, bestu_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [STAT_W-1:0]    hits_reg, hits_next;
    logic [STAT_W-1:0]    misses_reg, misses_next;
    kind_t                kind_reg, kind_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic [DATA_BITS-1:0] rd_reg, rd_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     cap;
    logic                 match;
    logic                 scan_more;
    logic [DATA_BITS-1:0] touch_data;

    always_comb
    begin
        if (max_blocks == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (32'(max_blocks) > MAX_ENTRIES)
        begin
            cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap = CNT_W'(max_blocks);
        end
    end

    assign match     = pv_reg && (mem_rdata.id == id_reg);
    assign scan_more = scan_reg < count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pv_reg     <= 1'b0;
            count_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pv_reg     <= pv_next;
            count_reg  <= count_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        pidx_reg  <= pidx_next;
        pos_reg   <= pos_next;
        best_reg  <= best_next;
        bestu_reg <= bestu_next;
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        data_reg  <= data_next;
        rd_reg    <= rd_next;
        found_reg <= found_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        pv_next     = pv_reg;
        pidx_next   = pidx_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        bestu_next  = bestu_reg;
        count_next  = count_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        data_next   = data_reg;
        rd_next     = rd_reg;
        found_next  = found_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_req     = '0;
        touch_data  = (kind_reg == KIND_STORE) ? data_reg : mem_rdata.data;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next  = kind_t'(in_kind);
                    id_next    = in_id;
                    data_next  = in_data;
                    rd_next    = '0;
                    found_next = 1'b0;
                    scan_next  = '0;
                    pv_next    = 1'b0;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (match || (!pv_reg && !scan_more))
                begin
                    // the unused kind reports nothing found
                    found_next = match && (kind_reg != KIND_NONE);
                    pv_next    = 1'b0;
                    scan_next  = '0;
                    bestu_next = '1;
                    pos_next   = pidx_reg;
                    state_next = ST_DONE;
                    case (kind_reg) inside
                        KIND_STORE, KIND_RETRIEVE:
                        begin
                            if (match)
                            begin
                                // touch: bump usage, or age everyone else at the ceiling
                                mem_req.wr_en        = 1'b1;
                                mem_req.wr_addr      = pidx_reg;
                                mem_req.wr_data      = mem_rdata;
                                mem_req.wr_data.data = touch_data;
                                if (mem_rdata.usage < max_blocks)
                                begin
                                    mem_req.wr_data.usage = mem_rdata.usage + USE_W'(1);
                                end
                                else
                                begin
                                    state_next = ST_AGE;
                                end
                                if (kind_reg == KIND_RETRIEVE)
                                begin
                                    rd_next   = mem_rdata.data;
                                    hits_next = hits_reg + STAT_W'(1);
                                end
                            end
                            else if (kind_reg == KIND_RETRIEVE)
                            begin
                                misses_next = misses_reg + STAT_W'(1);
                            end
                            else if (count_reg >= cap)
                            begin
                                state_next = ST_MINSCAN;
                            end
                            else
                            begin
                                state_next = ST_APPEND;
                            end
                        end
                        KIND_DROP:
                        begin
                            if (match)
                            begin
                                scan_next  = CNT_W'(pidx_reg) + CNT_W'(1);
                                state_next = ST_SHIFT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else if (scan_more)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[IDX_W-1:0];
                    pidx_next       = scan_reg[IDX_W-1:0];
                    scan_next       = scan_reg + CNT_W'(1);
                    pv_next         = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
            end

            ST_AGE:
            begin
                if (pv_reg && (pidx_reg != pos_reg) && (mem_rdata.usage != '0))
                begin
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_addr       = pidx_reg;
                    mem_req.wr_data       = mem_rdata;
                    mem_req.wr_data.usage = mem_rdata.usage - USE_W'(1);
                end
                if (scan_more)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[IDX_W-1:0];
                    pidx_next       = scan_reg[IDX_W-1:0];
                    scan_next       = scan_reg + CNT_W'(1);
                    pv_next         = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_MINSCAN:
            begin
                // lowest usage wins, a tie goes to the later position
                if (pv_reg && (mem_rdata.usage <= bestu_reg))
                begin
                    best_next  = pidx_reg;
                    bestu_next = mem_rdata.usage;
                end
                if (scan_more)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[IDX_W-1:0];
                    pidx_next       = scan_reg[IDX_W-1:0];
                    scan_next       = scan_reg + CNT_W'(1);
                    pv_next         = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        scan_next  = CNT_W'(best_reg) + CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (pv_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pidx_reg - IDX_W'(1);
                    mem_req.wr_data = mem_rdata;
                end
                if (scan_more)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[IDX_W-1:0];
                    pidx_next       = scan_reg[IDX_W-1:0];
                    scan_next       = scan_reg + CNT_W'(1);
                    pv_next         = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        scan_next  = '0;
                        bestu_next = '1;
                        if (kind_reg == KIND_DROP)
                        begin
                            state_next = ST_DONE;
                        end
                        else if ((count_reg - CNT_W'(1)) >= cap)
                        begin
                            state_next = ST_MINSCAN;
                        end
                        else
                        begin
                            state_next = ST_APPEND;
                        end
                    end
                end
            end

            ST_APPEND:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = count_reg[IDX_W-1:0];
                mem_req.wr_data.id    = id_reg;
                mem_req.wr_data.usage = USE_W'(1);
                mem_req.wr_data.data  = data_reg;
                count_next            = count_reg + CNT_W'(1);
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.found      = found_reg;
    assign res.read_data  = rd_reg;
    assign res.hit_count  = hits_reg;
    assign res.miss_count = misses_reg;

endmodule

// ===== hw/rtl/usage_count_block_cache_unit.sv =====
// Top level of the usage-count block cache: config register, entry RAM, output stage.
//
// Fully associative block cache with least-frequently-used eviction. Each beat on the
// slave side is one store, retrieve, drop or unused kind and yields exactly one beat on the master
// side. Items are handled one at a time by a sequencer around a single entry RAM with
// one read and one write port, so the work is a set of linear sweeps over the N
// occupied entries: a search (shorter on an early hit), a sweep to age the other entries
// when a hit is already at the usage ceiling, a minimum scan then compaction per evicted
// entry on a store miss plus an append, a compaction on a drop, and a hand-over. The
// result waits in an output register, so the next beat is taken while the last one has
// not been collected. Write max_blocks only when idle.
module usage_count_block_cache_unit
    import ucbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         max_blocks_we,
    input  logic [6:0]   max_blocks_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_id [63:0], store_data [127:64]
    input  logic [1:0]   s_tuser,   // kind [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // read_data [63:0], hit_count [95:64], miss_count [127:96]
    output logic [0:0]   m_tuser    // found [0]
);

    logic [USE_W-1:0] max_blocks_reg;
    mem_req_t         mem_req;
    entry_t           mem_rdata;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             out_valid_reg;
    result_t          out_reg;

    // hold the capacity and usage ceiling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_blocks_reg <= USE_W'(64);
        end
        else if (max_blocks_we)
        begin
            max_blocks_reg <= max_blocks_wdata;
        end
    end

    ucbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rdata)
    );

    ucbc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_blocks (max_blocks_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_id      (s_tdata[63:0]),
        .in_data    (s_tdata[64 +: DATA_BITS]),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // load the output register when it is empty or its beat is taken
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tuser        = out_reg.found;
    assign m_tdata[63:0]  = 64'(out_reg.read_data);
    assign m_tdata[95:64] = out_reg.hit_count;
    assign m_tdata[127:96] = out_reg.miss_count;

endmodule

// ===== hw/rtl/ucbc_checker.sv =====
// Port-level checker of the usage-count block cache, bound to the top level.
module ucbc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // a result beat stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a miss never carries data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0)
        else $error("read_data nonzero without a hit");

    // no result beat during reset
    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result beat during reset");

endmodule

bind usage_count_block_cache_unit ucbc_checker u_ucbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_usage_count_block_cache_unit.sv =====
// Self-checking testbench of the usage-count block cache, scoreboard class and top module.
module tb_usage_count_block_cache_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ucbc_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int ITEMS_PER_PHASE = 197;
    localparam int POOL_SIZE = 24;

    // Cache predictor with the store of expected results.
    class cache_scoreboard;
        logic [ID_W-1:0]      ids[MAX_ENTRIES];
        logic [USE_W-1:0]     usage[MAX_ENTRIES];
        logic [DATA_BITS-1:0] data[MAX_ENTRIES];
        int                   count;
        logic [STAT_W-1:0]    hits;
        logic [STAT_W-1:0]    misses;
        logic [6:0]           max_blocks;
        result_t              expected[$];
        int                   errors;

        function new();
            count = 0;
            hits = '0;
            misses = '0;
            max_blocks = 7'd64;
            errors = 0;
        endfunction

        function void remove_at(int pos);
            for (int i = pos; i + 1 < count; i++)
            begin
                ids[i] = ids[i+1];
                usage[i] = usage[i+1];
                data[i] = data[i+1];
            end
            count--;
        endfunction

        function void bump_usage(int pos);
            if (usage[pos] < max_blocks)
                usage[pos] = usage[pos] + 7'd1;
            else
                for (int i = 0; i < count; i++)
                    if (i != pos && usage[i] > 0)
                        usage[i] = usage[i] - 7'd1;
        endfunction

        function void evict_least_used();
            int best;
            int best_use;
            best = 0;
            best_use = 1000;
            for (int i = 0; i < count; i++)
                if (usage[i] <= best_use)
                begin
                    best_use = usage[i];
                    best = i;
                end
            remove_at(best);
        endfunction

        // Work out the result of one accepted input beat.
        function void note_item(kind_t kind, logic [ID_W-1:0] id, logic [DATA_BITS-1:0] wdata);
            int      pos;
            int      cap;
            result_t r;
            pos = -1;
            r = '0;
            for (int i = 0; i < count; i++)
                if (pos < 0 && ids[i] == id)
                    pos = i;
            case (kind)
                KIND_STORE:
                begin
                    if (pos >= 0)
                    begin
                        r.found = 1'b1;
                        data[pos] = wdata;
                        bump_usage(pos);
                    end
                    else
                    begin
                        cap = (max_blocks == 0) ? 1 : (max_blocks > MAX_ENTRIES) ? MAX_ENTRIES
                                                                                : max_blocks;
                        while (count >= cap)
                            evict_least_used();
                        ids[count] = id;
                        data[count] = wdata;
                        usage[count] = 7'd1;
                        count++;
                    end
                end
                KIND_RETRIEVE:
                begin
                    if (pos >= 0)
                    begin
                        r.found = 1'b1;
                        r.read_data = data[pos];
                        bump_usage(pos);
                        hits++;
                    end
                    else
                        misses++;
                end
                KIND_DROP:
                begin
                    if (pos >= 0)
                    begin
                        r.found = 1'b1;
                        remove_at(pos);
                    end
                end
                default: ;
            endcase
            r.hit_count = hits;
            r.miss_count = misses;
            expected.insert(expected.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0b actual %0b", $realtime, want.found, got.found);
                errors++;
            end
            if (got.read_data !== want.read_data)
            begin
                $display("%0t: read_data expected %h actual %h", $realtime,
                         want.read_data, got.read_data);
                errors++;
            end
            if (got.hit_count !== want.hit_count)
            begin
                $display("%0t: hit_count expected %0d actual %0d", $realtime,
                         want.hit_count, got.hit_count);
                errors++;
            end
            if (got.miss_count !== want.miss_count)
            begin
                $display("%0t: miss_count expected %0d actual %0d", $realtime,
                         want.miss_count, got.miss_count);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         max_blocks_we;
    logic [6:0]   max_blocks_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // block_id [63:0], store_data [127:64]
    logic [1:0]   s_tuser;   // kind [1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // read_data [63:0], hit_count [95:64], miss_count [127:96]
    logic [0:0]   m_tuser;   // found [0]

    cache_scoreboard  cache_sb;
    int               cycle_count;
    int               items_sent;
    logic [ID_W-1:0]  id_pool[POOL_SIZE];

    usage_count_block_cache_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_blocks_we    (max_blocks_we),
        .max_blocks_wdata (max_blocks_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Collect result beats and hand them to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            cache_sb.check_result({m_tuser[0], m_tdata[63:0], m_tdata[95:64], m_tdata[127:96]});
    end

    // Receiver: stall on a pattern of its own; once, hold off for a long stretch so
    // the output register fills and the block stops taking beats.
    initial
    begin
        int mode;
        int span;
        bit long_done;
        long_done = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_done && items_sent >= 500)
            begin
                long_done = 1;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                case (mode)
                    0: m_tready <= 1'b1;                       // stretch with no stalls
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(kind_t kind, logic [ID_W-1:0] id, logic [DATA_BITS-1:0] wdata);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {wdata, id};
        do
            @(posedge clk);
        while (!s_tready);
        cache_sb.note_item(kind, id, wdata);
        items_sent++;
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Write the register only once every result is back and the block is idle.
    task automatic set_max_blocks(logic [6:0] value);
        pause_sender(1);
        while (cache_sb.expected.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        max_blocks_we <= 1'b1;
        max_blocks_wdata <= value;
        @(posedge clk);
        max_blocks_we <= 1'b0;
        cache_sb.max_blocks = value;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic refill_pool();
        foreach (id_pool[i])
            id_pool[i] = rand64();
        id_pool[0] = '0;
        id_pool[1] = '1;
    endtask

    // Mostly pooled ids so hits, ageing and evictions happen; the rest is noise.
    task automatic random_phase(int items, int pool_used);
        int              burst;
        int              pick;
        kind_t           kind;
        logic [ID_W-1:0] id;
        for (int n = 0; n < items; )
        begin
            burst = $urandom_range(1, 25);
            for (int b = 0; b < burst && n < items; b++, n++)
            begin
                pick = $urandom_range(0, 99);
                kind = (pick < 42) ? KIND_STORE : (pick < 78) ? KIND_RETRIEVE :
                       (pick < 95) ? KIND_DROP : KIND_NONE;
                id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, pool_used - 1)]
                                                : rand64();
                send_beat(kind, id, rand64());
            end
            pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    initial
    begin
        logic [6:0] phase_max[8];
        cache_sb = new();
        cycle_count = 0;
        items_sent = 0;
        max_blocks_we = 1'b0;
        max_blocks_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_NONE;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of id and data, every kind, hits and misses.
        send_beat(KIND_STORE, '0, '1);
        send_beat(KIND_STORE, '1, '0);
        send_beat(KIND_RETRIEVE, '0, '0);
        send_beat(KIND_RETRIEVE, 64'd5, '1);
        send_beat(KIND_STORE, '0, 64'h5a5a_0f0f_a5a5_f0f0);   // store hit overwrites
        send_beat(KIND_DROP, '1, '0);
        send_beat(KIND_DROP, 64'd7, '0);                       // drop miss
        send_beat(KIND_NONE, '1, '1);                          // unused kind
        send_beat(KIND_RETRIEVE, '0, '0);

        // Low ceiling: usage saturates and the other entries age instead.
        set_max_blocks(7'd2);
        send_beat(KIND_STORE, 64'd9, 64'd99);
        send_beat(KIND_RETRIEVE, '0, '0);
        send_beat(KIND_RETRIEVE, '0, '0);
        send_beat(KIND_RETRIEVE, '0, '0);
        send_beat(KIND_STORE, 64'd10, 64'd100);                // evicts the least used

        // Fill under a wide capacity, then shrink so one miss evicts several entries.
        set_max_blocks(7'd64);
        for (int i = 0; i < 10; i++)
            send_beat(KIND_STORE, 64'd100 + i, rand64());
        set_max_blocks(7'd3);
        send_beat(KIND_STORE, 64'd200, rand64());
        send_beat(KIND_RETRIEVE, 64'd200, '0);

        // Random phases across settings, the extremes among them.
        phase_max = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd16, 7'd4, 7'd40, 7'd8};
        foreach (phase_max[p])
        begin
            set_max_blocks(phase_max[p]);
            refill_pool();
            random_phase(ITEMS_PER_PHASE, (phase_max[p] > 40 || phase_max[p] < 2) ? POOL_SIZE
                                                                                : 12);
        end
        set_max_blocks(7'($urandom_range(1, 64)));
        random_phase(ITEMS_PER_PHASE, POOL_SIZE);
        pause_sender(1);

        // Drain, then keep watching for any stray beat.
        while (cache_sb.expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (cache_sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
